// ===== rtl/sfe_pkg.sv =====
package sfe_pkg;

	localparam logic [7:0] START_BYTE   = 8'hFA;
	localparam logic [7:0] PAYLOAD_MARK = 8'hFB;
	localparam logic [7:0] STOP_BYTE    = 8'hFE;
	localparam logic [7:0] CRC_POLY     = 8'h07;
	localparam logic [7:0] CRC_TOP      = 8'h80;

	localparam int MAX_BURST = 8;
	localparam int CNT_W     = $clog2(MAX_BURST + 1);
	localparam int IDX_W     = $clog2(MAX_BURST);

	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_SIX   = CNT_W'(6);
	localparam logic [CNT_W-1:0] CNT_SEVEN = CNT_W'(7);
	localparam logic [CNT_W-1:0] CNT_EIGHT = CNT_W'(8);

	// All output bytes caused by one request, in emit order from entry 0
	typedef struct packed {
		logic [MAX_BURST-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      close;
	} burst_t;

	// Fold one byte into a CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/sfe_build.sv =====
module sfe_build
	import sfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] payload_length,
	output burst_t      burst
);

	logic [15:0] remaining_q;
	logic [7:0]  crc_q;
	logic [15:0] remaining_d;
	logic [7:0]  crc_d;

	logic [7:0] c_start;
	logic [7:0] c_lo;
	logic [7:0] hcrc;
	logic [7:0] c_hdr;
	logic [7:0] c_mark;
	logic [7:0] c_data_open;
	logic [7:0] c_data_mid;

	// CRC chain over the frame header and the first payload byte, plus the running CRC step for later payload bytes
	always_comb begin
		c_start     = crc8_byte(8'h00, START_BYTE);
		c_lo        = crc8_byte(c_start, payload_length[7:0]);
		hcrc        = crc8_byte(c_lo, payload_length[15:8]);
		c_hdr       = crc8_byte(hcrc, hcrc);
		c_mark      = crc8_byte(c_hdr, PAYLOAD_MARK);
		c_data_open = crc8_byte(c_mark, payload_byte);
		c_data_mid  = crc8_byte(crc_q, payload_byte);
	end

	// Assemble the byte burst and the next frame state for this request
	always_comb begin
		burst       = '0;
		remaining_d = remaining_q;
		crc_d       = crc_q;
		if (remaining_q == 16'd0) begin
			burst.bytes[0] = START_BYTE;
			burst.bytes[1] = payload_length[7:0];
			burst.bytes[2] = payload_length[15:8];
			burst.bytes[3] = hcrc;
			burst.bytes[4] = PAYLOAD_MARK;
			if (payload_length == 16'd0) begin
				// empty frame: close right after the payload mark
				burst.bytes[5] = c_mark;
				burst.bytes[6] = STOP_BYTE;
				burst.count    = CNT_SEVEN;
				burst.close    = 1'b1;
				remaining_d    = 16'd0;
				crc_d          = 8'h00;
			end else if (payload_length == 16'd1) begin
				burst.bytes[5] = payload_byte;
				burst.bytes[6] = c_data_open;
				burst.bytes[7] = STOP_BYTE;
				burst.count    = CNT_EIGHT;
				burst.close    = 1'b1;
				remaining_d    = 16'd0;
				crc_d          = 8'h00;
			end else begin
				burst.bytes[5] = payload_byte;
				burst.count    = CNT_SIX;
				burst.close    = 1'b0;
				remaining_d    = payload_length - 16'd1;
				crc_d          = c_data_open;
			end
		end else begin
			burst.bytes[0] = payload_byte;
			if (remaining_q == 16'd1) begin
				burst.bytes[1] = c_data_mid;
				burst.bytes[2] = STOP_BYTE;
				burst.count    = CNT_THREE;
				burst.close    = 1'b1;
				remaining_d    = 16'd0;
				crc_d          = 8'h00;
			end else begin
				burst.count    = CNT_ONE;
				burst.close    = 1'b0;
				remaining_d    = remaining_q - 16'd1;
				crc_d          = c_data_mid;
			end
		end
	end

	// Advance frame state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= 16'd0;
			crc_q       <= 8'h00;
		end else if (load) begin
			remaining_q <= remaining_d;
			crc_q       <= crc_d;
		end
	end

endmodule

// ===== rtl/sfe_serialize.sv =====
module sfe_serialize
	import sfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       load,
	input  burst_t     burst,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_last
);

	burst_t           burst_s1;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             pop;
	logic             last;

	// Drain the held burst one byte per cycle while out_stall is low; take a new one when idle or as the last byte leaves
	assign last     = ({1'b0, idx_q} + CNT_ONE) == burst_s1.count;
	assign pop      = busy_q && !out_stall;
	assign in_stall = busy_q && !(pop && last);
	assign load     = in_valid && !in_stall;

	assign out_valid  = busy_q;
	assign out_byte   = burst_s1.bytes[idx_q];
	assign run_last   = last;
	assign frame_last = last && burst_s1.close;

	// Hold burst payload
	always_ff @(posedge clk) begin
		if (load) begin
			burst_s1 <= burst;
		end
	end

	// Track occupancy and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (pop && last) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, idx_q} < burst_s1.count))
		else $error("read index beyond burst length");

	a_stop_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (out_byte == STOP_BYTE))
		else $error("frame end flagged on a byte other than stop");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(load && busy_q) |-> (pop && last))
		else $error("new burst loaded over an undelivered one");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !last && !load) |=> (busy_q && idx_q == $past(idx_q) + IDX_W'(1)))
		else $error("read position did not advance after a pop");

endmodule

// ===== rtl/serial_frame_encoder_crc8.sv =====
// Latency: first byte of a request appears the cycle after it is accepted.
// Throughput: one output byte per cycle while out_stall is low. A request
// yields 1 to 8 bytes: 1 mid-frame (3 when it closes the frame) and 6 to 8
// on a frame open; a new one is taken when idle or as the last byte leaves.
// Reset: arst_n low clears frame state (idle, CRC zero) and empties the output.
module serial_frame_encoder_crc8
	import sfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] payload_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        frame_last
);

	burst_t burst;
	logic   load;

	sfe_build u_build (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.payload_byte   (payload_byte),
		.payload_length (payload_length),
		.burst          (burst)
	);

	sfe_serialize u_serialize (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.load       (load),
		.burst      (burst),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_last (frame_last)
	);

endmodule
